### rtl/assert_macros.svh
// Assertion macros used by the RTL of the topological sort core.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TSK_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define TSK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/tsk_pkg.sv
// Package of the topological sort core: fixed field widths and command codes.
// Depends on nothing; used by the top level.
package tsk_pkg;

    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

endpackage

### rtl/tsk_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module tsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/topological_sort_kahn_core.sv
// Topological sort core (Kahn's algorithm) over a loaded edge store.
// Input channel (in_valid/in_ready): cmd = 0 adds the edge from_vertex -> to_vertex,
// cmd = 1 runs the sort. In an add, the source word of the per-vertex memory is read
// as the item is accepted, rewritten with the new list tail while the edge memories
// are written, then the target word is read and its degree raised. A dropped edge
// (vertex out of range or store full) sets a flag. One item is in work at a time.
// A run first scans the vertices below vertex_count (capped at MAX_VERTICES), pushing
// those of degree zero onto the ready queue, then for every vertex popped from it walks
// its outgoing edges, lowering each target's degree, paced by the per-vertex memory port.
// Output channel (out_valid/out_ready): one item per ordered vertex, the final one
// marked is_last; an empty ordering gives one item with has_vertex = 0. The output
// register is loaded one vertex behind the walk, so is_last is known when it leaves.
// If the receiver stalls, the walk waits at the next emission; a new item is accepted
// as soon as the run has handed its final result to the output register.
// Configuration channel (cfg_valid/cfg_ready) writes vertex_count and is always ready.
// Reset (rst_n, asynchronous) empties the graph and sets vertex_count to 64; the
// per-vertex store is marked empty through valid bits, which each run also clears.
`include "assert_macros.svh"

module topological_sort_kahn_core #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tsk_pkg::COUNT_W-1:0]      vertex_count,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [tsk_pkg::VERTEX_W-1:0]     from_vertex,
    input  logic [tsk_pkg::VERTEX_W-1:0]     to_vertex,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tsk_pkg::VERTEX_W-1:0]     vertex,
    output logic                             has_vertex,
    output logic                             is_last,
    output logic                             all_ordered,
    output logic                             edges_dropped
);

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int UW  = $clog2(MAX_EDGES + 1);
    localparam int CW  = tsk_pkg::COUNT_W;
    // Vertex word: {has_edges, head, tail, degree}.
    localparam int TAIL_LO = UW;
    localparam int HEAD_LO = UW + EAW;
    localparam int HAS_BIT = UW + 2 * EAW;
    localparam int VWORD   = UW + 2 * EAW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_SRC, S_ADD_DST_RD, S_ADD_DST, S_SEED_RD, S_SEED_CHK,
        S_POP, S_POP_D, S_EMIT, S_VRD, S_ERD, S_ED, S_TD, S_FINISH
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       vc_reg;
    logic [UW-1:0]       edge_used_reg;
    logic                dropped_reg;
    logic [VW-1:0]       src_reg;
    logic [VW-1:0]       dst_reg;
    logic [CW-1:0]       seed_reg;
    logic [CW-1:0]       fifo_head_reg;
    logic [CW-1:0]       fifo_tail_reg;
    logic [CW-1:0]       emit_cnt_reg;
    logic [VW-1:0]       cur_v_reg;
    logic [EAW-1:0]      cur_e_reg;
    logic [EAW-1:0]      cur_tail_reg;
    logic [VW-1:0]       tgt_reg;
    logic                last_edge_reg;
    logic                pend_valid_reg;
    logic [VW-1:0]       pend_vertex_reg;
    logic                vrd_ok_reg;
    logic [MAX_VERTICES-1:0] vvalid_reg;

    logic                         out_valid_reg;
    logic [tsk_pkg::VERTEX_W-1:0] vertex_reg;
    logic                         has_vertex_reg;
    logic                         is_last_reg;
    logic                         all_ordered_reg;
    logic                         edges_dropped_reg;

    logic [CW-1:0]    nv;
    logic             in_acc;
    logic             add_ok;
    logic             out_free;
    logic             out_load;

    logic             vram_we;
    logic [VW-1:0]    vram_waddr;
    logic [VWORD-1:0] vram_wdata;
    logic [VW-1:0]    vram_raddr;
    logic [VWORD-1:0] vram_rdata;
    logic [VWORD-1:0] vword;
    logic [UW-1:0]    v_deg;
    logic [EAW-1:0]   v_head;
    logic [EAW-1:0]   v_tail;
    logic             v_has;

    logic             tram_we;
    logic [VW-1:0]    tram_rdata;
    logic             nram_we;
    logic [EAW-1:0]   nram_waddr;
    logic [EAW-1:0]   nram_rdata;
    logic [EAW-1:0]   eram_raddr;

    logic             fram_we;
    logic [VW-1:0]    fram_wdata;
    logic [VW-1:0]    fram_rdata;

    assign nv = (vc_reg > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign add_ok    = ({1'b0, from_vertex} < nv) && ({1'b0, to_vertex} < nv)
                       && (edge_used_reg < UW'(MAX_EDGES));
    // The output register takes a new item when the walk hands one over.
    assign out_load  = out_free && (((state_reg == S_EMIT) && pend_valid_reg)
                                    || (state_reg == S_FINISH));

    // An entry whose valid bit is clear reads as degree zero with no edges.
    assign vword  = vrd_ok_reg ? vram_rdata : '0;
    assign v_deg  = vword[UW-1:0];
    assign v_tail = vword[TAIL_LO +: EAW];
    assign v_head = vword[HEAD_LO +: EAW];
    assign v_has  = vword[HAS_BIT];

    always_comb
    begin
        vram_we    = 1'b0;
        vram_waddr = src_reg;
        vram_wdata = vword;
        vram_raddr = src_reg;
        tram_we    = 1'b0;
        nram_we    = 1'b0;
        nram_waddr = v_tail;
        eram_raddr = cur_e_reg;
        fram_we    = 1'b0;
        fram_wdata = seed_reg[VW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                vram_raddr = from_vertex[VW-1:0];
            end
            S_ADD_SRC:
            begin
                vram_we    = 1'b1;
                vram_waddr = src_reg;
                vram_wdata = {1'b1, (v_has ? v_head : edge_used_reg[EAW-1:0]),
                              edge_used_reg[EAW-1:0], v_deg};
                tram_we    = 1'b1;
                nram_we    = v_has;
            end
            S_ADD_DST_RD:
            begin
                vram_raddr = dst_reg;
            end
            S_ADD_DST:
            begin
                vram_we    = 1'b1;
                vram_waddr = dst_reg;
                vram_wdata = {vword[VWORD-1:UW], v_deg + UW'(1)};
            end
            S_SEED_RD:
            begin
                vram_raddr = seed_reg[VW-1:0];
            end
            S_SEED_CHK:
            begin
                fram_we = (v_deg == '0) && (fifo_tail_reg < CW'(MAX_VERTICES));
            end
            S_EMIT:
            begin
                vram_raddr = cur_v_reg;
            end
            S_ED:
            begin
                vram_raddr = tram_rdata;
            end
            S_TD:
            begin
                vram_we    = (v_deg != '0);
                vram_waddr = tgt_reg;
                vram_wdata = {vword[VWORD-1:UW], v_deg - UW'(1)};
                fram_we    = (v_deg == UW'(1)) && (fifo_tail_reg < CW'(MAX_VERTICES));
                fram_wdata = tgt_reg;
            end
            default:
            begin
            end
        endcase
    end

    tsk_ram #(.WIDTH(VWORD), .DEPTH(MAX_VERTICES)) u_vertex_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    tsk_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_target_ram (
        .clk   (clk),
        .we    (tram_we),
        .waddr (edge_used_reg[EAW-1:0]),
        .wdata (dst_reg),
        .raddr (eram_raddr),
        .rdata (tram_rdata)
    );

    tsk_ram #(.WIDTH(EAW), .DEPTH(MAX_EDGES)) u_next_ram (
        .clk   (clk),
        .we    (nram_we),
        .waddr (nram_waddr),
        .wdata (edge_used_reg[EAW-1:0]),
        .raddr (eram_raddr),
        .rdata (nram_rdata)
    );

    tsk_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ready_ram (
        .clk   (clk),
        .we    (fram_we),
        .waddr (fifo_tail_reg[VW-1:0]),
        .wdata (fram_wdata),
        .raddr (fifo_head_reg[VW-1:0]),
        .rdata (fram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            vc_reg            <= tsk_pkg::COUNT_RESET;
            edge_used_reg     <= '0;
            dropped_reg       <= 1'b0;
            src_reg           <= '0;
            dst_reg           <= '0;
            seed_reg          <= '0;
            fifo_head_reg     <= '0;
            fifo_tail_reg     <= '0;
            emit_cnt_reg      <= '0;
            cur_v_reg         <= '0;
            cur_e_reg         <= '0;
            cur_tail_reg      <= '0;
            tgt_reg           <= '0;
            last_edge_reg     <= 1'b0;
            pend_valid_reg    <= 1'b0;
            pend_vertex_reg   <= '0;
            vrd_ok_reg        <= 1'b0;
            vvalid_reg        <= '0;
            out_valid_reg     <= 1'b0;
            vertex_reg        <= '0;
            has_vertex_reg    <= 1'b0;
            is_last_reg       <= 1'b0;
            all_ordered_reg   <= 1'b0;
            edges_dropped_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                vc_reg <= vertex_count;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            vrd_ok_reg <= vvalid_reg[vram_raddr];
            if (vram_we)
            begin
                vvalid_reg[vram_waddr] <= 1'b1;
            end
            if (fram_we)
            begin
                fifo_tail_reg <= fifo_tail_reg + CW'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        src_reg <= from_vertex[VW-1:0];
                        dst_reg <= to_vertex[VW-1:0];
                        if (cmd == tsk_pkg::CMD_RUN)
                        begin
                            fifo_head_reg <= '0;
                            fifo_tail_reg <= '0;
                            seed_reg      <= '0;
                            emit_cnt_reg  <= '0;
                            state_reg     <= S_SEED_RD;
                        end
                        else if (add_ok)
                        begin
                            state_reg <= S_ADD_SRC;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                end
                S_ADD_SRC:
                begin
                    state_reg <= S_ADD_DST_RD;
                end
                S_ADD_DST_RD:
                begin
                    state_reg <= S_ADD_DST;
                end
                S_ADD_DST:
                begin
                    edge_used_reg <= edge_used_reg + UW'(1);
                    state_reg     <= S_IDLE;
                end
                S_SEED_RD:
                begin
                    state_reg <= (seed_reg == nv) ? S_POP : S_SEED_CHK;
                end
                S_SEED_CHK:
                begin
                    seed_reg  <= seed_reg + CW'(1);
                    state_reg <= S_SEED_RD;
                end
                S_POP:
                begin
                    if (fifo_head_reg < fifo_tail_reg)
                    begin
                        fifo_head_reg <= fifo_head_reg + CW'(1);
                        state_reg     <= S_POP_D;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_POP_D:
                begin
                    cur_v_reg <= fram_rdata;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // The previous vertex leaves now that a later one is known.
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            vertex_reg        <= tsk_pkg::VERTEX_W'(pend_vertex_reg);
                            has_vertex_reg    <= 1'b1;
                            is_last_reg       <= 1'b0;
                            all_ordered_reg   <= 1'b0;
                            edges_dropped_reg <= dropped_reg;
                        end
                        pend_valid_reg  <= 1'b1;
                        pend_vertex_reg <= cur_v_reg;
                        emit_cnt_reg    <= emit_cnt_reg + CW'(1);
                        state_reg       <= S_VRD;
                    end
                end
                S_VRD:
                begin
                    cur_e_reg    <= v_head;
                    cur_tail_reg <= v_tail;
                    state_reg    <= v_has ? S_ERD : S_POP;
                end
                S_ERD:
                begin
                    state_reg <= S_ED;
                end
                S_ED:
                begin
                    tgt_reg       <= tram_rdata;
                    cur_e_reg     <= nram_rdata;
                    last_edge_reg <= (cur_e_reg == cur_tail_reg);
                    // Targets at or above a lowered count are skipped.
                    if ({{(CW-VW){1'b0}}, tram_rdata} < nv)
                    begin
                        state_reg <= S_TD;
                    end
                    else
                    begin
                        state_reg <= (cur_e_reg == cur_tail_reg) ? S_POP : S_ERD;
                    end
                end
                S_TD:
                begin
                    state_reg <= last_edge_reg ? S_POP : S_ERD;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        is_last_reg       <= 1'b1;
                        edges_dropped_reg <= dropped_reg;
                        if (pend_valid_reg)
                        begin
                            vertex_reg      <= tsk_pkg::VERTEX_W'(pend_vertex_reg);
                            has_vertex_reg  <= 1'b1;
                            all_ordered_reg <= (emit_cnt_reg == nv);
                        end
                        else
                        begin
                            vertex_reg      <= '0;
                            has_vertex_reg  <= 1'b0;
                            all_ordered_reg <= (nv == '0);
                        end
                        pend_valid_reg <= 1'b0;
                        vvalid_reg     <= '0;
                        edge_used_reg  <= '0;
                        dropped_reg    <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign vertex        = vertex_reg;
    assign has_vertex    = has_vertex_reg;
    assign is_last       = is_last_reg;
    assign all_ordered   = all_ordered_reg;
    assign edges_dropped = edges_dropped_reg;

    // A run never leaves a vertex held back once the block is idle again.
    `TSK_ASSERT_IMP(a_idle_no_pending, in_ready, !pend_valid_reg)
    // The ready queue is never read past what has been pushed.
    `TSK_ASSERT_IMP(a_fifo_order, 1'b1, fifo_head_reg <= fifo_tail_reg)
    // The edge store never grows past its capacity.
    `TSK_ASSERT_IMP(a_edge_bound, 1'b1, edge_used_reg <= UW'(MAX_EDGES))
    // Leaving the finish state always hands over a final result.
    `TSK_ASSERT_NEXT(a_finish_last, (state_reg == S_FINISH) && out_free,
                     out_valid_reg && is_last_reg)

endmodule
